@@ sv/sorted_priority_queue_unit_defines.svh @@
// Assertion macros for the sorted priority queue.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ sv/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [0:0] {
    ModeInsert = 1'b0,
    ModeRemove = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
  } entry_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic ins;         // insert step in progress
    logic rem;         // remove step in progress
    logic occupied;    // cell index below the stored count
    logic left_after;  // new entry goes after the left neighbor
  } cell_ctrl_t;

endpackage

@@ sv/spq_if.sv @@
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] item_data;
  logic [31:0] item_key;

  modport source (output valid, mode, item_data, item_key, input ready);
  modport sink   (input valid, mode, item_data, item_key, output ready);
endinterface

interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] removed_data;
  logic [31:0] removed_key;
  logic [31:0] head_data;
  logic [31:0] head_key;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic [1:0]  status;

  modport source (output valid, removed_data, removed_key, head_data, head_key,
                  entry_count, is_empty, status, input ready);
  modport sink   (input valid, removed_data, removed_key, head_data, head_key,
                  entry_count, is_empty, status, output ready);
endinterface

@@ sv/sorted_priority_queue_unit.sv @@
// Sorted min-priority queue of spq_pkg::Depth entries (data word plus key).
// Input channel in_i: mode 0 inserts item_data under item_key, mode 1 removes
// the entry with the least key. Equal keys leave in arrival order.
// Output channel out_o: one result beat per accepted input beat, carrying the
// removed entry (zero unless a remove succeeded), the head entry and count
// after the step, an empty flag and a status code (ok, insert on full,
// remove on empty). A failed step leaves the queue unchanged.
// The result beat is registered and valid in the cycle after the input beat.
// Throughput: one item per cycle while the receiver takes results. The whole
// row of cells compares its keys against the new key and shifts in the same
// cycle, so that single compare-and-shift step sets the rate.
// Reset clears the entry count and the output valid; cell contents are
// not reset and are never read before they are written.
// When the receiver stalls, the result beat holds and in_i.ready drops until
// it is taken; a new input beat is taken in the same cycle the result leaves.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CntW;

  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  logic            accept, ins_go, rem_go;
  spq_pkg::entry_t new_entry;

  spq_pkg::entry_t     cell_q   [Depth];
  spq_pkg::entry_t     cell_d   [Depth];
  logic [Depth-1:0]    after;
  spq_pkg::cell_ctrl_t ctrl     [Depth];

  logic            out_valid_q;
  logic [31:0]     rem_data_q, rem_key_q, head_data_q, head_key_q;
  logic [CntW-1:0] out_count_q;
  spq_pkg::status_e status_q, status_d;

  // Take a new beat whenever the result register is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  assign ins_go = accept && (in_i.mode == spq_pkg::ModeInsert) && !full;
  assign rem_go = accept && (in_i.mode == spq_pkg::ModeRemove) && !empty;

  assign new_entry.key  = in_i.item_key;
  assign new_entry.data = spq_pkg::DataW'(in_i.item_data);

  // Row of cells: each compares against the new key and shifts toward its
  // neighbor on insert (right) or remove (left).
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign ctrl[i].ins      = ins_go;
    assign ctrl[i].rem      = rem_go;
    assign ctrl[i].occupied = (count_q > CntW'(i));
    if (i == 0) begin : g_head
      assign ctrl[i].left_after = 1'b1;
    end else begin : g_body
      assign ctrl[i].left_after = after[i-1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .new_i     (new_entry),
      .left_i    ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i-1]),
      .right_i   ((i == Depth-1) ? spq_pkg::entry_t'('0)
                                 : cell_q[(i == Depth-1) ? i : i+1]),
      .entry_o   (cell_q[i]),
      .entry_d_o (cell_d[i]),
      .after_o   (after[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_go) begin
      count_d = count_q + CntW'(1);
    end else if (rem_go) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    status_d = spq_pkg::StOk;
    if (in_i.mode == spq_pkg::ModeInsert) begin
      if (full) begin
        status_d = spq_pkg::StFull;
      end
    end else if (empty) begin
      status_d = spq_pkg::StEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: capture the step outcome, hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_data_q  <= rem_go ? 32'(cell_q[0].data) : '0;
      rem_key_q   <= rem_go ? cell_q[0].key : '0;
      head_data_q <= (count_d != '0) ? 32'(cell_d[0].data) : '0;
      head_key_q  <= (count_d != '0) ? cell_d[0].key : '0;
      out_count_q <= count_d;
      status_q    <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.removed_data = rem_data_q;
  assign out_o.removed_key  = rem_key_q;
  assign out_o.head_data    = head_data_q;
  assign out_o.head_key     = head_key_q;
  assign out_o.entry_count  = 5'(out_count_q);
  assign out_o.is_empty     = (out_count_q == '0);
  assign out_o.status       = status_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(Depth), "entry count above depth")
  `SPQ_ASSERT_NEXT(a_rem_dec, rem_go, count_q == $past(count_q) - CntW'(1), "remove count slip")
  `SPQ_ASSERT_NEXT(a_ins_inc, ins_go, count_q == $past(count_q) + CntW'(1), "insert count slip")
  `SPQ_ASSERT(a_full_status, out_valid_q && status_q == spq_pkg::StFull |-> full, "full flag slip")
  `SPQ_ASSERT(a_result_count, out_valid_q |-> out_count_q == count_q, "result count stale")

endmodule

@@ sv/spq_cell.sv @@
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output spq_pkg::entry_t    entry_d_o,
  output logic               after_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // New entry sorts after this one: keeps arrival order on equal keys.
  assign after_o = ctrl_i.occupied && (entry_q.key <= new_i.key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rem) begin
      entry_d = right_i;
    end else if (ctrl_i.ins && !after_o) begin
      entry_d = ctrl_i.left_after ? new_i : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins || ctrl_i.rem) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

@@ tb/sorted_priority_queue_unit_test.sv @@
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseItems = 343;
  localparam int unsigned MaxReports = 30;

  typedef struct {
    spq_pkg::mode_e op;
    logic [31:0]    data;
    logic [31:0]    key;
    bit             hold_for_drain;  // wait until every result is back first
  } queue_op_t;

  typedef struct packed {
    logic [31:0]              removed_data;
    logic [31:0]              removed_key;
    logic [31:0]              head_data;
    logic [31:0]              head_key;
    logic [spq_pkg::CntW-1:0] entry_count;
    logic                     is_empty;
    spq_pkg::status_e         status;
  } queue_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  sorted_priority_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the sorted cell row, ascending by key.
  logic [31:0] shadow_key [spq_pkg::Depth];
  logic [31:0] shadow_data [spq_pkg::Depth];
  int unsigned shadow_count = 0;

  queue_op_t     pending_ops[$];
  queue_result_t predicted_results[$];

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 61;
  bit          in_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned inserts_ok = 0;
  int unsigned inserts_dropped = 0;
  int unsigned removes_ok = 0;
  int unsigned removes_on_empty = 0;
  int unsigned peak_fill = 0;

  // Apply one beat to the shadow row and return what the block should report.
  task automatic queue_step_result(input spq_pkg::mode_e op, input logic [31:0] data,
                                   input logic [31:0] key, output queue_result_t res);
    int unsigned slot;
    int unsigned idx;
    res = '0;
    res.status = spq_pkg::StOk;
    if (op == spq_pkg::ModeInsert) begin
      if (shadow_count >= spq_pkg::Depth) begin
        res.status = spq_pkg::StFull;
        inserts_dropped++;
      end else begin
        // Equal keys go behind the stored ones, so they leave in arrival order.
        slot = 0;
        while (slot < shadow_count && shadow_key[slot] <= key) slot++;
        for (idx = shadow_count; idx > slot; idx--) begin
          shadow_key[idx]  = shadow_key[idx - 1];
          shadow_data[idx] = shadow_data[idx - 1];
        end
        shadow_key[slot]  = key;
        shadow_data[slot] = data;
        shadow_count++;
        inserts_ok++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = spq_pkg::StEmpty;
        removes_on_empty++;
      end else begin
        res.removed_data = shadow_data[0];
        res.removed_key  = shadow_key[0];
        for (idx = 1; idx < shadow_count; idx++) begin
          shadow_key[idx - 1]  = shadow_key[idx];
          shadow_data[idx - 1] = shadow_data[idx];
        end
        shadow_count--;
        removes_ok++;
      end
    end
    if (shadow_count != 0) begin
      res.head_data = shadow_data[0];
      res.head_key  = shadow_key[0];
    end
    res.entry_count = shadow_count[spq_pkg::CntW-1:0];
    res.is_empty    = (shadow_count == 0);
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < MaxReports)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: present the next beat at the falling edge once the last one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.mode      <= spq_pkg::ModeInsert;
      in_bus.item_data <= '0;
      in_bus.item_key  <= '0;
    end else if (!in_bus.valid || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_ops[0].hold_for_drain && predicted_results.size() != 0)) begin
        in_bus.valid     <= 1'b1;
        in_bus.mode      <= pending_ops[0].op;
        in_bus.item_data <= pending_ops[0].data;
        in_bus.item_key  <= pending_ops[0].key;
        void'(pending_ops.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random.
  always @(negedge clk_i) begin
    if (!rst_ni) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk_i) begin : monitor
    queue_result_t fresh;
    queue_result_t want;
    if (rst_ni) begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        queue_step_result(spq_pkg::mode_e'(in_bus.mode), in_bus.item_data,
                          in_bus.item_key, fresh);
        predicted_results.push_back(fresh);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_results.size() == 0) begin
          if (mismatch_count < MaxReports)
            $display("%0t: result beat with nothing expected, expected none actual %h",
                     $time, out_bus.head_key);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("removed_data", want.removed_data, out_bus.removed_data);
          check_field("removed_key", want.removed_key, out_bus.removed_key);
          check_field("head_data", want.head_data, out_bus.head_data);
          check_field("head_key", want.head_key, out_bus.head_key);
          check_field("entry_count", 32'(want.entry_count), 32'(out_bus.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_bus.is_empty));
          check_field("status", 32'(want.status), 32'(out_bus.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run stuck, %0d items queued, %0d results outstanding",
               $time, pending_ops.size(), predicted_results.size());
      $display("[sorted_priority_queue_unit] ERROR");
      $finish;
    end
  end

  task automatic add_op(input spq_pkg::mode_e op, input logic [31:0] data,
                        input logic [31:0] key, input bit hold);
    queue_op_t item;
    item.op             = op;
    item.data           = data;
    item.key            = key;
    item.hold_for_drain = hold;
    pending_ops.push_back(item);
  endtask

  // Runs of inserts, runs of removes and mixed runs, so the row fills up,
  // overflows, drains and underflows over and over.
  task automatic add_random_phase(input int unsigned count);
    int unsigned    added;
    int unsigned    run_kind;
    int unsigned    run_len;
    int unsigned    key_span;
    int unsigned    n;
    spq_pkg::mode_e op;
    logic [31:0]    key;
    added = 0;
    while (added < count) begin
      run_kind = $urandom_range(3);
      run_len  = $urandom_range(20, 4);
      key_span = $urandom_range(3);
      for (n = 0; n < run_len && added < count; n++) begin
        case (run_kind)
          0: op = spq_pkg::ModeInsert;
          1: op = spq_pkg::ModeRemove;
          default: op = ($urandom_range(99) < 55) ? spq_pkg::ModeInsert
                                                  : spq_pkg::ModeRemove;
        endcase
        case (key_span)
          // Narrow keys give plenty of ties.
          0: key = $urandom_range(7);
          1: key = $urandom();
          2: key = $urandom_range(2) == 0 ? 32'h0 :
                   ($urandom_range(1) == 0 ? 32'hFFFF_FFFF : $urandom());
          default: key = {2'($urandom_range(3)), 28'h0, 2'($urandom_range(3))};
        endcase
        add_op(op, $urandom(), key, added == 0 || $urandom_range(49) == 0);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || in_bus.valid || predicted_results.size() != 0);
  endtask

  initial begin
    int unsigned n;
    in_bus.valid     = 1'b0;
    in_bus.mode      = spq_pkg::ModeInsert;
    in_bus.item_data = '0;
    in_bus.item_key  = '0;
    out_bus.ready    = 1'b0;

    // Remove on an empty queue, key extremes, ties in arrival order,
    // fill to the top, insert on full, then take a few off the head.
    add_op(spq_pkg::ModeRemove, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'h0000_00A1, 32'h0000_0007, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'h0000_00B2, 32'h0000_0007, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'h0000_00C3, 32'h0000_0007, 1'b0);
    for (n = 5; n < spq_pkg::Depth; n++)
      add_op(spq_pkg::ModeInsert, $urandom(), 32'h8000_0000 - n * 3, 1'b0);
    add_op(spq_pkg::ModeInsert, 32'h5555_5555, 32'h0000_0001, 1'b0);
    add_op(spq_pkg::ModeRemove, 32'h0, 32'h0, 1'b0);
    add_op(spq_pkg::ModeRemove, 32'h0, 32'h0, 1'b0);
    add_op(spq_pkg::ModeRemove, 32'h0, 32'h0, 1'b0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_random_phase(PhaseItems);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 25;
    add_random_phase(PhaseItems);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_phase(PhaseItems);
    wait_drained();

    // Leave room for any stray beat to show up.
    repeat (10) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty),",
             inserts_ok + inserts_dropped, inserts_dropped,
             removes_ok + removes_on_empty, removes_on_empty);
    $display("peak fill %0d of %0d, under sender/receiver stall mixes 25/61, 61/25, 0/0.",
             peak_fill, spq_pkg::Depth);
    if (mismatch_count == 0) begin
      $display("[sorted_priority_queue_unit] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[sorted_priority_queue_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_test.sv
